// File: rtl/srtw_pkg.sv
// Shared types, constants and table-building functions for the ripple texture warp.
// Used by srtw_sine_rom, srtw_texel_mem and sine_ripple_texture_warp.
package srtw_pkg;

    localparam int COORD_W      = 6;
    localparam int FLAT_SIDE    = 1 << COORD_W;
    localparam int TEXEL_ADDR_W = 2 * COORD_W;
    localparam int TEXEL_DEPTH  = 1 << TEXEL_ADDR_W;
    localparam int TEXEL_W      = 8;

    localparam int PHASE_W      = 13;
    localparam int ANGLE_STEPS  = 1 << PHASE_W;
    localparam int QUARTER_W    = PHASE_W - 2;
    localparam int QUARTER      = 1 << QUARTER_W;
    localparam int SINE_W       = 16;

    localparam int AMP_W        = 3;
    localparam int SPEED_W      = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [PHASE_W-1:0] PX1_OFFSET = PHASE_W'(900);
    localparam logic [PHASE_W-1:0] PX2_OFFSET = PHASE_W'(300);
    localparam logic [PHASE_W-1:0] PY1_OFFSET = PHASE_W'(700);
    localparam logic [PHASE_W-1:0] PY2_OFFSET = PHASE_W'(1200);

    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SPEED = 2'd2;

    localparam logic [AMP_W-1:0]   AMP_FIRST_RESET  = 3'd2;
    localparam logic [AMP_W-1:0]   AMP_SECOND_RESET = 3'd2;
    localparam logic [SPEED_W-1:0] WAVE_SPEED_RESET = 8'd40;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    typedef logic [SINE_W-1:0] qsine_tab_t [QUARTER];

    // (a*b) >> 62 from 32-bit partial products
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, p0, p1, p2, p3, mid, hi, lo;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        p0  = al * bl;
        p1  = al * bh;
        p2  = ah * bl;
        p3  = ah * bh;
        mid = (p0 >> 32) + {32'd0, p1[31:0]} + {32'd0, p2[31:0]};
        hi  = p3 + (p1 >> 32) + (p2 >> 32) + (mid >> 32);
        lo  = (mid << 32) | {32'd0, p0[31:0]};
        return (hi << 2) | (lo >> 62);
    endfunction

    // Floor of num / den by shift and subtract, for table building only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine at the middle of step k of the first quarter, 16 fractional bits
    function automatic logic [SINE_W-1:0] quarter_sine(input int k);
        logic [63:0] odd, x, x2, term, sum, den;
        odd  = 64'(2 * k + 1);
        x    = (PI_Q62 >> 13) * odd + (((PI_Q62 & 64'd8191) * odd) >> 13);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++)
        begin
            den  = 64'((2 * n) * (2 * n + 1));
            term = div_u64(mul_q62(term, x2), den);
            if ((n & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return SINE_W'(sum >> 46);
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t tab;
        for (int k = 0; k < QUARTER; k++)
        begin
            tab[k] = quarter_sine(k);
        end
        return tab;
    endfunction

endpackage

// File: rtl/sine_ripple_texture_warp.sv
// Top level of the rippling-water texture warp: pipeline, configuration and memories.
// Depends on srtw_pkg, srtw_sine_rom and srtw_texel_mem.
//
// One transaction is accepted every clock cycle (busy stays low). A write
// transaction stores texel_in at (pos_x, pos_y) and gives no result. A read
// transaction gives texel_out with done high for exactly one cycle; done is
// registered alongside the texel memory's read data, so texel_out is valid
// while done is high. Results come out in order and cannot be
// held off, so the receiver must take each one as it appears. The pipeline is
// four stages: tick times wave speed, phase forming and sine ROM lookup,
// scaling and wrapping the displaced position, and the texel memory port,
// which sees writes and reads in transaction order so a read always sees
// every earlier write. The sine table is a constant ROM; there is no start-up
// pass. Reads of a texel never written return an undefined value.
module sine_ripple_texture_warp
    import srtw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [COORD_W-1:0]     pos_x,
    input  logic [COORD_W-1:0]     pos_y,
    input  logic [TEXEL_W-1:0]     texel_in,
    input  logic [PHASE_W-1:0]     tick,
    output logic                   done,
    output logic [TEXEL_W-1:0]     texel_out,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic [AMP_W-1:0]   amp_first_reg;
    logic [AMP_W-1:0]   amp_second_reg;
    logic [SPEED_W-1:0] wave_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_first_reg  <= AMP_FIRST_RESET;
            amp_second_reg <= AMP_SECOND_RESET;
            wave_speed_reg <= WAVE_SPEED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_AMP_FIRST:  amp_first_reg  <= cfg_data[AMP_W-1:0];
                CFG_AMP_SECOND: amp_second_reg <= cfg_data[AMP_W-1:0];
                CFG_WAVE_SPEED: wave_speed_reg <= cfg_data[SPEED_W-1:0];
                default:        ;
            endcase
        end
    end

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: advance = tick * speed
    logic                 s1_valid_reg;
    logic                 s1_read_reg;
    logic [COORD_W-1:0]   s1_x_reg;
    logic [COORD_W-1:0]   s1_y_reg;
    logic [TEXEL_W-1:0]   s1_texel_reg;
    logic [PHASE_W-1:0]   s1_adv_reg;
    logic [PHASE_W+SPEED_W-1:0] adv_full;

    assign adv_full = tick * wave_speed_reg;

    // stage 2: sine magnitudes from ROM, signs carried alongside
    logic                 s2_valid_reg;
    logic                 s2_read_reg;
    logic [COORD_W-1:0]   s2_x_reg;
    logic [COORD_W-1:0]   s2_y_reg;
    logic [TEXEL_W-1:0]   s2_texel_reg;
    logic [3:0]           s2_neg_reg;

    // stage 3: texel memory address
    logic                    s3_valid_reg;
    logic                    s3_read_reg;
    logic [TEXEL_ADDR_W-1:0] s3_addr_reg;
    logic [TEXEL_W-1:0]      s3_texel_reg;
    logic [TEXEL_ADDR_W-1:0] s3_addr_next;

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg && s3_read_reg;
        end
    end

    // phases from stage 1
    logic [PHASE_W-1:0] adv3, adv4, adv5;
    logic [PHASE_W-1:0] phase [4];
    logic [QUARTER_W-1:0] rom_addr [4];
    logic [3:0]         neg_next;
    logic [SINE_W-1:0]  mag [4];

    assign adv3 = s1_adv_reg + (s1_adv_reg << 1);
    assign adv4 = s1_adv_reg << 2;
    assign adv5 = s1_adv_reg + (s1_adv_reg << 2);

    // order: x first, x second, y first, y second
    assign phase[0] = {s1_y_reg, 7'd0} + adv5 + PX1_OFFSET;
    assign phase[1] = {s1_x_reg[COORD_W-2:0], 8'd0} + adv4 + PX2_OFFSET;
    assign phase[2] = {s1_x_reg, 7'd0} + adv3 + PY1_OFFSET;
    assign phase[3] = {s1_y_reg[COORD_W-2:0], 8'd0} + adv4 + PY2_OFFSET;

    // fold into the first quarter: mirror on odd quarters, negate on the second half
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rom_addr[i] = phase[i][PHASE_W-2] ? ~phase[i][QUARTER_W-1:0]
                                              : phase[i][QUARTER_W-1:0];
            neg_next[i] = phase[i][PHASE_W-1];
        end
    end

    srtw_sine_rom u_rom_x
    (
        .clk    (clk),
        .addr_a (rom_addr[0]),
        .addr_b (rom_addr[1]),
        .data_a (mag[0]),
        .data_b (mag[1])
    );

    srtw_sine_rom u_rom_y
    (
        .clk    (clk),
        .addr_a (rom_addr[2]),
        .addr_b (rom_addr[3]),
        .data_a (mag[2]),
        .data_b (mag[3])
    );

    // scale each term, floor after shift by 16, wrap sums to the texture
    logic signed [SINE_W:0]   sval [4];
    logic signed [SINE_W+4:0] prod [4];
    logic [COORD_W-1:0]       ripple [4];
    logic [COORD_W-1:0]       sx, sy;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sval[i]   = s2_neg_reg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
            prod[i]   = sval[i] * $signed({1'b0, ((i & 1) == 0) ? amp_first_reg
                                                                : amp_second_reg});
            ripple[i] = COORD_W'(prod[i] >>> 16);
        end
        sx = s2_x_reg + ripple[0] + ripple[1];
        sy = s2_y_reg + ripple[2] + ripple[3];
        s3_addr_next = s2_read_reg ? {sy, sx} : {s2_y_reg, s2_x_reg};
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_read_reg  <= action;
        s1_x_reg     <= pos_x;
        s1_y_reg     <= pos_y;
        s1_texel_reg <= texel_in;
        s1_adv_reg   <= adv_full[PHASE_W-1:0];

        s2_read_reg  <= s1_read_reg;
        s2_x_reg     <= s1_x_reg;
        s2_y_reg     <= s1_y_reg;
        s2_texel_reg <= s1_texel_reg;
        s2_neg_reg   <= neg_next;

        s3_read_reg  <= s2_read_reg;
        s3_addr_reg  <= s3_addr_next;
        s3_texel_reg <= s2_texel_reg;
    end

    srtw_texel_mem u_texels
    (
        .clk     (clk),
        .wr_en   (s3_valid_reg && !s3_read_reg),
        .addr    (s3_addr_reg),
        .wr_data (s3_texel_reg),
        .rd_data (texel_out)
    );

    assign done = done_reg;

endmodule

// File: rtl/srtw_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
// Contents are built at elaboration by srtw_pkg::build_qsine.
module srtw_sine_rom
    import srtw_pkg::*;
(
    input  logic                 clk,
    input  logic [QUARTER_W-1:0] addr_a,
    input  logic [QUARTER_W-1:0] addr_b,
    output logic [SINE_W-1:0]    data_a,
    output logic [SINE_W-1:0]    data_b
);

    localparam qsine_tab_t QSINE = build_qsine();

    logic [SINE_W-1:0] data_a_reg;
    logic [SINE_W-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        data_a_reg <= QSINE[addr_a];
        data_b_reg <= QSINE[addr_b];
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// File: rtl/srtw_texel_mem.sv
// Source texel store: single port, one access per cycle (a write cycle also reads the old word), registered read.
// Uses widths from srtw_pkg.
module srtw_texel_mem
    import srtw_pkg::*;
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [TEXEL_ADDR_W-1:0] addr,
    input  logic [TEXEL_W-1:0]      wr_data,
    output logic [TEXEL_W-1:0]      rd_data
);

    logic [TEXEL_W-1:0] mem [TEXEL_DEPTH];
    logic [TEXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for sine_ripple_texture_warp: texel writes, warped reads, registers.
// Depends on srtw_pkg for port widths and register indexes; predicts results in-house.
`timescale 1ns / 100ps

module tb_top;
    import srtw_pkg::*;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] PI_SCALED = 64'hC90FDAA22168C235;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PHASE_W-1:0] tick;
        logic [TEXEL_W-1:0] texel;
    } warp_read_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic action;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [TEXEL_W-1:0] texel_in;
    logic [PHASE_W-1:0] tick;
    logic done;
    logic [TEXEL_W-1:0] texel_out;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int sine_tab [ANGLE_STEPS];
    logic [TEXEL_W-1:0] texture_shadow [TEXEL_DEPTH];
    bit texel_written [TEXEL_DEPTH];
    logic [AMP_W-1:0] amp_first;
    logic [AMP_W-1:0] amp_second;
    logic [SPEED_W-1:0] wave_speed;
    warp_read_t expected_texels [$];
    warp_read_t oldest;
    int fail_count = 0;
    int sender_idle_pct = 0;

    sine_ripple_texture_warp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .texel_in  (texel_in),
        .tick      (tick),
        .done      (done),
        .texel_out (texel_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // floor(a*b / 2^62), kept to 64 bits
    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[125:62];
    endfunction

    // Taylor series of sin at the middle of quarter step k, 2^62 scale, floored to 16.16
    function automatic int mid_step_sine(input int k);
        logic [63:0] odd, angle, angle_sq, term, acc;
        odd      = 64'(2 * k + 1);
        angle    = (PI_SCALED >> 13) * odd + (((PI_SCALED & 64'd8191) * odd) >> 13);
        angle_sq = q62_product(angle, angle);
        term     = angle;
        acc      = angle;
        for (int n = 1; n <= 12; n++)
        begin
            term = q62_product(term, angle_sq) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        return int'(acc >> 46);
    endfunction

    task automatic build_sine_table();
        int v;
        for (int i = 0; i < QUARTER; i++)
        begin
            v = mid_step_sine(i);
            sine_tab[i]                   = v;
            sine_tab[2 * QUARTER - 1 - i] = v;
            sine_tab[2 * QUARTER + i]     = -v;
            sine_tab[4 * QUARTER - 1 - i] = -v;
        end
    endtask

    // Source address that a read at (x, y, t) fetches under the current registers
    function automatic logic [TEXEL_ADDR_W-1:0] warp_source(input logic [COORD_W-1:0] x,
                                                             input logic [COORD_W-1:0] y,
                                                             input logic [PHASE_W-1:0] t);
        int adv, px1, px2, py1, py2, sx, sy, a1, a2;
        adv = int'(t) * int'(wave_speed);
        a1  = int'(amp_first);
        a2  = int'(amp_second);
        px1 = (int'(y) * 128 + adv * 5 + int'(PX1_OFFSET)) & (ANGLE_STEPS - 1);
        px2 = (int'(x) * 256 + adv * 4 + int'(PX2_OFFSET)) & (ANGLE_STEPS - 1);
        py1 = (int'(x) * 128 + adv * 3 + int'(PY1_OFFSET)) & (ANGLE_STEPS - 1);
        py2 = (int'(y) * 256 + adv * 4 + int'(PY2_OFFSET)) & (ANGLE_STEPS - 1);
        sx  = int'(x) + 128 + ((sine_tab[px1] * a1) >>> 16) + ((sine_tab[px2] * a2) >>> 16);
        sy  = int'(y) + 128 + ((sine_tab[py1] * a1) >>> 16) + ((sine_tab[py2] * a2) >>> 16);
        return {sy[COORD_W-1:0], sx[COORD_W-1:0]};
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic send_item(input logic act, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [TEXEL_W-1:0] texel,
                             input logic [PHASE_W-1:0] t);
        warp_read_t rd;
        logic [TEXEL_ADDR_W-1:0] src;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            idle_cycle();
        end
        @(negedge clk);
        start    <= 1'b1;
        action   <= act;
        pos_x    <= x;
        pos_y    <= y;
        texel_in <= texel;
        tick     <= t;
        do
            @(posedge clk);
        while (busy);
        if (act == ACT_WRITE)
        begin
            texture_shadow[{y, x}] = texel;
            texel_written[{y, x}]  = 1'b1;
        end
        else
        begin
            src      = warp_source(x, y, t);
            rd.x     = x;
            rd.y     = y;
            rd.tick  = t;
            rd.texel = texture_shadow[src];
            expected_texels.push_back(rd);
        end
    endtask

    // Make sure the displaced source exists, then issue the read
    task automatic read_texel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [PHASE_W-1:0] t);
        logic [TEXEL_ADDR_W-1:0] src;
        src = warp_source(x, y, t);
        if (!texel_written[src])
        begin
            send_item(ACT_WRITE, src[COORD_W-1:0], src[TEXEL_ADDR_W-1:COORD_W],
                      TEXEL_W'($urandom), PHASE_W'($urandom));
        end
        send_item(ACT_READ, x, y, TEXEL_W'($urandom), t);
    endtask

    // Drop start, hold until every read has answered, then let writes clear the pipeline
    task automatic drain_results();
        int waited;
        waited = 0;
        idle_cycle();
        while (expected_texels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_texels.size() != 0)
        begin
            note_failure($sformatf("%0d reads never answered", expected_texels.size()));
            expected_texels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        start     <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_AMP_FIRST:  amp_first  = data[AMP_W-1:0];
            CFG_AMP_SECOND: amp_second = data[AMP_W-1:0];
            CFG_WAVE_SPEED: wave_speed = data[SPEED_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_all_registers(input logic [CFG_DATA_W-1:0] a1,
                                     input logic [CFG_DATA_W-1:0] a2,
                                     input logic [CFG_DATA_W-1:0] spd);
        set_register(CFG_AMP_FIRST, a1);
        set_register(CFG_AMP_SECOND, a2);
        set_register(CFG_WAVE_SPEED, spd);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_texels.size() == 0)
            begin
                note_failure($sformatf("unexpected result texel_out=%02h", texel_out));
            end
            else
            begin
                oldest = expected_texels.pop_front();
                if (texel_out !== oldest.texel)
                begin
                    note_failure($sformatf("read x=%0d y=%0d tick=%0d: texel_out exp %02h got %02h",
                                           oldest.x, oldest.y, oldest.tick, oldest.texel,
                                           texel_out));
                end
            end
        end
    end

    // Reads under the register values left by reset
    task automatic test_reset_values();
        send_item(ACT_WRITE, 6'd0, 6'd0, 8'h00, 13'd0);
        read_texel(6'd0, 6'd0, 13'd0);
        read_texel(6'd63, 6'd63, 13'd8191);
        drain_results();
    endtask

    // Field and register extremes, overwrite, ignored index and masked data
    task automatic test_field_extremes();
        set_all_registers(8'd0, 8'd0, 8'd0);
        send_item(ACT_WRITE, 6'd63, 6'd0, 8'hFF, 13'd8191);
        send_item(ACT_WRITE, 6'd63, 6'd0, 8'h00, 13'd0);
        read_texel(6'd63, 6'd0, 13'd8191);
        send_item(ACT_WRITE, 6'd0, 6'd63, 8'hA5, 13'd0);
        read_texel(6'd0, 6'd63, 13'd0);
        read_texel(6'd0, 6'd63, 13'd4096);
        drain_results();
        set_all_registers(8'hFF, 8'hFF, 8'hFF);
        read_texel(6'd0, 6'd0, 13'd0);
        read_texel(6'd63, 6'd63, 13'd8191);
        read_texel(6'd0, 6'd63, 13'd8191);
        read_texel(6'd63, 6'd0, 13'd1);
        drain_results();
        set_register(CFG_UNUSED, 8'hFF);
        set_all_registers(8'h07, 8'h00, 8'd128);
        read_texel(6'd31, 6'd32, 13'd2048);
        read_texel(6'd32, 6'd31, 13'd6144);
        drain_results();
    endtask

    // Random traffic, mostly well-formed reads with their sources seeded first
    task automatic run_traffic(input int idle_pct, input int count, input bit pause_mid);
        sender_idle_pct = idle_pct;
        set_all_registers(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 25)
            begin
                send_item(ACT_WRITE, COORD_W'($urandom), COORD_W'($urandom),
                          TEXEL_W'($urandom), PHASE_W'($urandom));
            end
            else
            begin
                read_texel(COORD_W'($urandom), COORD_W'($urandom), PHASE_W'($urandom));
            end
            if (pause_mid && i == count / 2)
            begin
                idle_cycle();
                drain_results();
            end
        end
        drain_results();
        sender_idle_pct = 0;
    endtask

    task automatic test_random_traffic();
        run_traffic(9, 200, 1'b1);
        run_traffic(54, 200, 1'b0);
        run_traffic(0, 200, 1'b0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = ACT_WRITE;
        pos_x     = '0;
        pos_y     = '0;
        texel_in  = '0;
        tick      = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        amp_first  = AMP_FIRST_RESET;
        amp_second = AMP_SECOND_RESET;
        wave_speed = WAVE_SPEED_RESET;
        build_sine_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_field_extremes();
        test_random_traffic();

        idle_cycle();
        drain_results();
        if (fail_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial
    begin
        #3ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
